// ===== sv/mha_pkg.sv =====
`timescale 1ns / 1ps

package mha_pkg;

    localparam int WINDOW_DEF   = 8;
    localparam int SAMP_W       = 17;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CORDIC_STEPS = 31;
    localparam int CORDIC_SCALE = 36;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int VEC_W        = 56;
    localparam int ANG_W        = 40;
    localparam int QUOT_W       = 14;

    // angle units are 1e-9 degree
    localparam logic [ANG_W-1:0] HALF_CD      = ANG_W'(64'd5000000);
    // smallest rounded value whose quotient exceeds a quarter turn
    localparam logic [ANG_W-1:0] SAT_LIMIT    = ANG_W'(64'd90010000000);
    localparam logic [QUOT_W-1:0] QUARTER_CD  = QUOT_W'(9000);
    localparam logic signed [15:0] HALF_TURN_CD = 16'sd18000;

    // a centidegree is 1e7 units = 78125 << 7: drop the 7 low bits, then divide by
    // 78125 with a reciprocal multiply that is exact for any 30-bit dividend
    localparam int CD_PRE_SH = 7;
    localparam int CD_DIV_W  = 30;
    localparam int CD_RCP_W  = 31;
    localparam int CD_RCP_SH = 47;
    localparam logic [CD_RCP_W-1:0] CD_RECIP = CD_RCP_W'(64'd1801439851);

    typedef enum logic {
        CFG_OFFSET_X = 1'b0,
        CFG_OFFSET_Y = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMP_W-1:0] x;
        logic signed [SAMP_W-1:0] y;
    } t_avg;

    function automatic logic [ANG_W-1:0] atan_units(input logic [STEP_W-1:0] idx);
        logic [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 40'd45000000000;
            5'd1:    v = 40'd26565051177;
            5'd2:    v = 40'd14036243468;
            5'd3:    v = 40'd7125016349;
            5'd4:    v = 40'd3576334375;
            5'd5:    v = 40'd1789910608;
            5'd6:    v = 40'd895173710;
            5'd7:    v = 40'd447614171;
            5'd8:    v = 40'd223810500;
            5'd9:    v = 40'd111905677;
            5'd10:   v = 40'd55952892;
            5'd11:   v = 40'd27976453;
            5'd12:   v = 40'd13988227;
            5'd13:   v = 40'd6994114;
            5'd14:   v = 40'd3497057;
            5'd15:   v = 40'd1748528;
            5'd16:   v = 40'd874264;
            5'd17:   v = 40'd437132;
            5'd18:   v = 40'd218566;
            5'd19:   v = 40'd109283;
            5'd20:   v = 40'd54642;
            5'd21:   v = 40'd27321;
            5'd22:   v = 40'd13660;
            5'd23:   v = 40'd6830;
            5'd24:   v = 40'd3415;
            5'd25:   v = 40'd1708;
            5'd26:   v = 40'd854;
            5'd27:   v = 40'd427;
            5'd28:   v = 40'd213;
            5'd29:   v = 40'd107;
            5'd30:   v = 40'd53;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/mha_front.sv =====
`timescale 1ns / 1ps

module mha_front #(
    parameter int WINDOW = mha_pkg::WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [15:0]   i_mag_x,
    input  logic signed [15:0]   i_mag_y,
    input  logic signed [15:0]   i_offset_x,
    input  logic signed [15:0]   i_offset_y,
    output logic                 o_avg_valid,
    input  logic                 i_avg_ready,
    output mha_pkg::t_avg        o_avg
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = mha_pkg::SAMP_W + SLOT_W;
    localparam int ABS_W  = SUM_W - 1;
    localparam int DIV_SH = ABS_W + SLOT_W;
    localparam int RCP_W  = ABS_W + 1;
    localparam int PROD_W = ABS_W + RCP_W;
    localparam int QUO_W  = PROD_W - DIV_SH;
    // ceil(2^DIV_SH / WINDOW): exact floor division for any |sum| < 2^ABS_W
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << DIV_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    typedef enum logic [1:0] {F_IDLE, F_ABS, F_MUL, F_PUSH} t_fstate;

    t_fstate                          r_state;
    logic signed [mha_pkg::SAMP_W-1:0] r_ring_x [WINDOW];
    logic signed [mha_pkg::SAMP_W-1:0] r_ring_y [WINDOW];
    logic [SLOT_W-1:0]                r_slot;
    logic signed [SUM_W-1:0]          r_sum_x, r_sum_y;
    logic [ABS_W-1:0]                 r_abs_x, r_abs_y;
    logic                             r_neg_x, r_neg_y;
    logic [PROD_W-1:0]                r_prod_x, r_prod_y;

    logic signed [mha_pkg::SAMP_W-1:0] new_x, new_y;
    logic signed [SUM_W-1:0]          n_sum_x, n_sum_y;
    logic signed [mha_pkg::SAMP_W-1:0] quo_x, quo_y;
    logic                             accept;

    assign accept = i_in_valid && (r_state == F_IDLE);
    assign o_in_ready = (r_state == F_IDLE);

    assign new_x = $signed({i_mag_x[15], i_mag_x}) - $signed({i_offset_x[15], i_offset_x});
    assign new_y = $signed({i_mag_y[15], i_mag_y}) - $signed({i_offset_y[15], i_offset_y});

    // running window sums: drop the entry being overwritten, add the new one
    assign n_sum_x = r_sum_x - SUM_W'(r_ring_x[r_slot]) + SUM_W'(new_x);
    assign n_sum_y = r_sum_y - SUM_W'(r_ring_y[r_slot]) + SUM_W'(new_y);

    assign quo_x = $signed(mha_pkg::SAMP_W'(r_prod_x[DIV_SH +: QUO_W]));
    assign quo_y = $signed(mha_pkg::SAMP_W'(r_prod_y[DIV_SH +: QUO_W]));

    // heading uses -avg_y, so the y sign is inverted here
    assign o_avg.x     = r_neg_x ? -quo_x : quo_x;
    assign o_avg.y     = r_neg_y ? quo_y : -quo_y;
    assign o_avg_valid = (r_state == F_PUSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_slot  <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring_x[k] <= '0;
                r_ring_y[k] <= '0;
            end
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_ring_x[r_slot] <= new_x;
                        r_ring_y[r_slot] <= new_y;
                        r_sum_x <= n_sum_x;
                        r_sum_y <= n_sum_y;
                        r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                        r_state <= F_ABS;
                    end
                end
                F_ABS: begin
                    r_neg_x <= r_sum_x[SUM_W-1];
                    r_neg_y <= r_sum_y[SUM_W-1];
                    r_abs_x <= r_sum_x[SUM_W-1] ? ABS_W'(-r_sum_x) : ABS_W'(r_sum_x);
                    r_abs_y <= r_sum_y[SUM_W-1] ? ABS_W'(-r_sum_y) : ABS_W'(r_sum_y);
                    r_state <= F_MUL;
                end
                F_MUL: begin
                    r_prod_x <= PROD_W'(r_abs_x) * PROD_W'(RECIP);
                    r_prod_y <= PROD_W'(r_abs_y) * PROD_W'(RECIP);
                    r_state  <= F_PUSH;
                end
                F_PUSH: begin
                    if (i_avg_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/mha_fifo.sv =====
`timescale 1ns / 1ps

module mha_fifo #(
    parameter int DEPTH = mha_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mha_pkg::t_avg  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output mha_pkg::t_avg  o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    mha_pkg::t_avg     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push, pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/mha_back.sv =====
`timescale 1ns / 1ps

module mha_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    output logic                o_q_ready,
    input  mha_pkg::t_avg       i_q_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [15:0]  o_heading
);

    localparam int VW = mha_pkg::VEC_W;
    localparam int AW = mha_pkg::ANG_W;
    localparam int QW = mha_pkg::QUOT_W;
    localparam int SW = mha_pkg::SAMP_W;
    localparam int DW = mha_pkg::CD_DIV_W;
    localparam int PW = mha_pkg::CD_DIV_W + mha_pkg::CD_RCP_W;
    localparam int PAD_W = VW - SW - mha_pkg::CORDIC_SCALE;
    localparam logic [mha_pkg::STEP_W-1:0] LAST_STEP =
        mha_pkg::STEP_W'(mha_pkg::CORDIC_STEPS - 1);

    typedef enum logic [2:0] {B_IDLE, B_ROT, B_RND, B_DIV, B_FIN} t_bstate;

    t_bstate                      r_state;
    logic signed [VW-1:0]         r_x, r_y;
    logic signed [AW-1:0]         r_z;
    logic [mha_pkg::STEP_W-1:0]   r_step;
    logic [DW-1:0]                r_scaled;
    logic [QW-1:0]                r_quot;
    logic                         r_neg_x, r_neg_y;
    logic                         r_out_valid;
    logic signed [15:0]           r_out_data;

    logic [SW-1:0]                abs_x, abs_y;
    logic signed [VW-1:0]         xs, ys;
    logic signed [AW-1:0]         ang;
    logic [AW-1:0]                rnd;
    logic [PW-1:0]                prod;
    logic signed [15:0]           h_base, h_quad, h_final;
    logic                         out_free;

    assign abs_x = i_q_data.x[SW-1] ? SW'(-i_q_data.x) : SW'(i_q_data.x);
    assign abs_y = i_q_data.y[SW-1] ? SW'(-i_q_data.y) : SW'(i_q_data.y);

    assign xs  = r_x >>> r_step;
    assign ys  = r_y >>> r_step;
    assign ang = $signed(mha_pkg::atan_units(r_step));
    assign rnd = AW'(r_z) + mha_pkg::HALF_CD;
    assign prod = PW'(r_scaled) * PW'(mha_pkg::CD_RECIP);

    assign h_base  = $signed({{(16 - QW){1'b0}}, r_quot});
    assign h_quad  = r_neg_x ? mha_pkg::HALF_TURN_CD - h_base : h_base;
    assign h_final = r_neg_y ? -h_quad : h_quad;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_q_ready   = (r_state == B_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_heading   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // the finishing state reloads the output register itself
            if (r_out_valid && i_out_ready && r_state != B_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_neg_x <= i_q_data.x[SW-1];
                        r_neg_y <= i_q_data.y[SW-1];
                        r_x <= $signed({{PAD_W{1'b0}}, abs_x,
                                        {mha_pkg::CORDIC_SCALE{1'b0}}});
                        r_y <= $signed({{PAD_W{1'b0}}, abs_y,
                                        {mha_pkg::CORDIC_SCALE{1'b0}}});
                        r_z    <= '0;
                        r_step <= '0;
                        r_quot <= '0;
                        if (abs_x == '0 && abs_y == '0) begin
                            // null vector: heading is zero
                            r_state <= B_FIN;
                        end else begin
                            r_state <= B_ROT;
                        end
                    end
                end
                B_ROT: begin
                    if (!r_y[VW-1]) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + ang;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - ang;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= B_RND;
                    end
                end
                B_RND: begin
                    // negative angle rounds to zero or below, clamped to zero
                    if (r_z[AW-1]) begin
                        r_quot  <= '0;
                        r_state <= B_FIN;
                    end else if (rnd >= mha_pkg::SAT_LIMIT) begin
                        r_quot  <= mha_pkg::QUARTER_CD;
                        r_state <= B_FIN;
                    end else begin
                        r_scaled <= rnd[mha_pkg::CD_PRE_SH +: DW];
                        r_state  <= B_DIV;
                    end
                end
                B_DIV: begin
                    // whole centidegrees by reciprocal multiply
                    r_quot  <= prod[mha_pkg::CD_RCP_SH +: QW];
                    r_state <= B_FIN;
                end
                B_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= h_final;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/magnetometer_heading_averager_top.sv =====
`timescale 1ns / 1ps
// Path from input transfer to heading offered: the front (magnitude, reciprocal multiply,
// queue push), then the back (queue pop, 31 CORDIC rotations, rounding, reciprocal multiply
// to centidegrees, output register). A clamped angle skips the multiply, a null vector
// skips rotations, rounding and multiply. The back takes no new vector until its heading
// is registered; the front takes no new sample until its average is queued.
// Synchronous active-low reset clears the offsets, the sample ring, sums and the queue.

module magnetometer_heading_averager_top #(
    parameter int WINDOW = mha_pkg::WINDOW_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [31:0]                           s_axis_tdata,  // mag_x[15:0], mag_y[31:16]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [15:0]                           m_axis_tdata,  // heading_centideg[15:0]
    input  logic                                  i_cfg_we,
    input  logic [$bits(mha_pkg::t_cfg_idx)-1:0]  i_cfg_idx,
    input  logic [15:0]                           i_cfg_data
);

    logic signed [15:0] r_offset_x, r_offset_y;

    logic           avg_valid, avg_ready;
    mha_pkg::t_avg  avg_data;
    logic           q_valid, q_ready;
    mha_pkg::t_avg  q_data;
    logic signed [15:0] heading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            unique case (mha_pkg::t_cfg_idx'(i_cfg_idx))
                mha_pkg::CFG_OFFSET_X: r_offset_x <= $signed(i_cfg_data);
                mha_pkg::CFG_OFFSET_Y: r_offset_y <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    mha_front #(
        .WINDOW (WINDOW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mag_x     ($signed(s_axis_tdata[15:0])),
        .i_mag_y     ($signed(s_axis_tdata[31:16])),
        .i_offset_x  (r_offset_x),
        .i_offset_y  (r_offset_y),
        .o_avg_valid (avg_valid),
        .i_avg_ready (avg_ready),
        .o_avg       (avg_data)
    );

    mha_fifo #(
        .DEPTH (mha_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (avg_valid),
        .o_ready (avg_ready),
        .i_data  (avg_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    mha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_data    (q_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_heading   (heading)
    );

    assign m_axis_tdata = heading;

endmodule

// ===== sv/mha_checker.sv =====
`timescale 1ns / 1ps

module mha_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic [31:0]                           s_axis_tdata,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [15:0]                           m_axis_tdata,
    input logic                                  i_cfg_we,
    input logic [$bits(mha_pkg::t_cfg_idx)-1:0]  i_cfg_idx,
    input logic [15:0]                           i_cfg_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // heading never leaves the half-turn range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) >= -16'sd18000) &&
                          ($signed(m_axis_tdata) <= 16'sd18000))
        else $error("heading out of range");

    // front takes one sample at a time
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transfer taken while ring update in progress");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule

bind magnetometer_heading_averager_top mha_checker u_mha_checker (.*);
